// ===== hdl/fdr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths and fixed-point constants of the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int COS_W  = 16;
	localparam int ETA_W  = 16;
	localparam int REFL_W = 17;

	// Square root unit: radicand is cos^2 of the transmitted angle in Q1.62.
	localparam int SQ_IN_W = 63;
	localparam int SQ_RT_W = 32;

	localparam logic [REFL_W-1:0] ONE_Q16 = REFL_W'(65536);
	localparam logic [24:0]       ONE_Q24 = 25'(1 << 24);

endpackage : fdr_pkg
`default_nettype wire

// ===== hdl/fdr_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_div_pipe
// Restoring divider, one quotient bit per register stage. Requires num <= den.
// ----------------------------------------------------------------------------
module fdr_div_pipe #(
	parameter int DW = 62,
	parameter int QB = 32,
	parameter int TW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag,
	output logic               out_valid,
	output logic [QB-1:0]      quot,
	output logic [TW-1:0]      out_tag
);

	logic          v_s   [QB];
	logic [DW:0]   rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] q_s   [QB];
	logic [TW-1:0] tag_s [QB];

	logic          v_in   [QB];
	logic [DW:0]   rem_in [QB];
	logic [DW-1:0] den_in [QB];
	logic [QB-1:0] q_in   [QB];
	logic [TW-1:0] tag_in [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic          ge;
		logic [DW:0]   diff;

		if (k == 0) begin : g_first
			assign v_in[k]   = in_valid;
			assign rem_in[k] = {1'b0, num};
			assign den_in[k] = den;
			assign q_in[k]   = '0;
			assign tag_in[k] = tag;
		end else begin : g_next
			assign v_in[k]   = v_s[k-1];
			assign rem_in[k] = rem_s[k-1];
			assign den_in[k] = den_s[k-1];
			assign q_in[k]   = q_s[k-1];
			assign tag_in[k] = tag_s[k-1];
		end

		assign ge   = rem_in[k] >= {1'b0, den_in[k]};
		assign diff = ge ? (rem_in[k] - {1'b0, den_in[k]}) : rem_in[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in[k];
			end
		end

		// Shift the partial remainder up for the next quotient bit.
		always_ff @(posedge clk) begin
			rem_s[k] <= {diff[DW-1:0], 1'b0};
			den_s[k] <= den_in[k];
			q_s[k]   <= {q_in[k][QB-2:0], ge};
			tag_s[k] <= tag_in[k];
		end
	end

	assign out_valid = v_s[QB-1];
	assign quot      = q_s[QB-1];
	assign out_tag   = tag_s[QB-1];

endmodule : fdr_div_pipe
`default_nettype wire

// ===== hdl/fdr_sqrt_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_sqrt_pipe
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module fdr_sqrt_pipe
	import fdr_pkg::*;
#(
	parameter int TW = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [SQ_IN_W-1:0] radicand,
	input  wire logic [TW-1:0]      tag,
	output logic                    out_valid,
	output logic [SQ_RT_W-1:0]      root,
	output logic [TW-1:0]           out_tag
);

	localparam int RW = 2 * SQ_RT_W;

	logic               v_s    [SQ_RT_W];
	logic [RW-1:0]      rem_s  [SQ_RT_W];
	logic [SQ_RT_W-1:0] root_s [SQ_RT_W];
	logic [TW-1:0]      tag_s  [SQ_RT_W];

	logic               v_in    [SQ_RT_W];
	logic [RW-1:0]      rem_in  [SQ_RT_W];
	logic [SQ_RT_W-1:0] root_in [SQ_RT_W];
	logic [TW-1:0]      tag_in  [SQ_RT_W];

	for (genvar k = 0; k < SQ_RT_W; k++) begin : g_stage
		localparam int B = SQ_RT_W - 1 - k;
		logic [RW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in[k]    = in_valid;
			assign rem_in[k]  = RW'(radicand);
			assign root_in[k] = '0;
			assign tag_in[k]  = tag;
		end else begin : g_next
			assign v_in[k]    = v_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign root_in[k] = root_s[k-1];
			assign tag_in[k]  = tag_s[k-1];
		end

		assign trial = (RW'(root_in[k]) << (B + 1)) + (RW'(1) << (2 * B));
		assign ge    = rem_in[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? (rem_in[k] - trial) : rem_in[k];
			root_s[k] <= root_in[k] | (SQ_RT_W'(ge) << B);
			tag_s[k]  <= tag_in[k];
		end
	end

	assign out_valid = v_s[SQ_RT_W-1];
	assign root      = root_s[SQ_RT_W-1];
	assign out_tag   = tag_s[SQ_RT_W-1];

endmodule : fdr_sqrt_pipe
`default_nettype wire

// ===== hdl/fresnel_dielectric_reflectance_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_unit
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy is held low, since the receiver
// cannot stall and every stage advances each cycle.
// Depth is set by the bit-serial stages: 32 for the cos^2 divider, 32 for the
// square root and 25 for the amplitude-ratio dividers.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_unit
	import fdr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [COS_W-1:0]  cos_incident,
	input  wire logic [ETA_W-1:0]  eta_incident,
	input  wire logic [ETA_W-1:0]  eta_transmitted,
	output logic                   done,
	output logic [REFL_W-1:0]      reflectance,
	output logic                   total_internal
);

	localparam int TAG1_W = 1 + COS_W + 2 * ETA_W;

	// ------------------------------------------------------------------
	// Stage 1: orient the ray and square the inputs.
	// A cosine of zero or below means the ray is leaving: swap the indices
	// and negate the cosine (the most negative code maps to +1.0).
	// ------------------------------------------------------------------
	logic             accept;
	logic             entering;
	logic [COS_W-1:0] c_abs;
	logic [ETA_W-1:0] ei_sel, et_sel;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign entering = !cos_incident[COS_W-1] && (cos_incident != '0);
	assign c_abs    = entering ? cos_incident : (~cos_incident + COS_W'(1));
	assign ei_sel   = entering ? eta_incident : eta_transmitted;
	assign et_sel   = entering ? eta_transmitted : eta_incident;

	logic             v_s1;
	logic [COS_W-1:0] c_s1;
	logic [ETA_W-1:0] ei_s1, et_s1;
	logic [30:0]      c2_s1;
	logic [31:0]      ei2_s1, et2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		c_s1   <= c_abs;
		ei_s1  <= ei_sel;
		et_s1  <= et_sel;
		c2_s1  <= 31'(c_abs * c_abs);
		ei2_s1 <= ei_sel * ei_sel;
		et2_s1 <= et_sel * et_sel;
	end

	// ------------------------------------------------------------------
	// Stage 2: lhs = ei^2 * sin^2 (scaled by 2^30), den = et^2 * 2^30.
	// ------------------------------------------------------------------
	logic [30:0] sin2;
	assign sin2 = 31'(1 << 30) - c2_s1;

	logic             v_s2;
	logic [COS_W-1:0] c_s2;
	logic [ETA_W-1:0] ei_s2, et_s2;
	logic [62:0]      lhs_s2;
	logic [61:0]      den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s2   <= c_s1;
		ei_s2  <= ei_s1;
		et_s2  <= et_s1;
		lhs_s2 <= 63'(ei2_s1 * sin2);
		den_s2 <= {et2_s1, 30'b0};
	end

	// ------------------------------------------------------------------
	// Stage 3: total internal reflection test and cos^2 numerator.
	// ------------------------------------------------------------------
	logic             v_s3;
	logic             tir_s3;
	logic [COS_W-1:0] c_s3;
	logic [ETA_W-1:0] ei_s3, et_s3;
	logic [61:0]      num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	// The numerator only matters when lhs < den, where it fits.
	always_ff @(posedge clk) begin
		tir_s3 <= lhs_s2 >= {1'b0, den_s2};
		c_s3   <= c_s2;
		ei_s3  <= ei_s2;
		et_s3  <= et_s2;
		num_s3 <= den_s2 - lhs_s2[61:0];
		den_s3 <= den_s2;
	end

	// ------------------------------------------------------------------
	// cos^2 of the transmitted angle as Q1.31, then its square root.
	// ------------------------------------------------------------------
	logic              v_dq;
	logic [31:0]       cos2t;
	logic [TAG1_W-1:0] tag_dq;

	fdr_div_pipe #(
		.DW(62),
		.QB(32),
		.TW(TAG1_W)
	) u_div_cos2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num       (num_s3),
		.den       (den_s3),
		.tag       ({tir_s3, c_s3, ei_s3, et_s3}),
		.out_valid (v_dq),
		.quot      (cos2t),
		.out_tag   (tag_dq)
	);

	logic               v_sq;
	logic [SQ_RT_W-1:0] root_sq;
	logic [TAG1_W-1:0]  tag_sq;

	fdr_sqrt_pipe #(
		.TW(TAG1_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_dq),
		.radicand  ({cos2t, 31'b0}),
		.tag       (tag_dq),
		.out_valid (v_sq),
		.root      (root_sq),
		.out_tag   (tag_sq)
	);

	logic             tir_sq;
	logic [COS_W-1:0] c_sq;
	logic [ETA_W-1:0] ei_sq, et_sq;
	logic [23:0]      ct23, ci23;

	assign {tir_sq, c_sq, ei_sq, et_sq} = tag_sq;
	assign ct23 = root_sq[31:8];
	assign ci23 = {c_sq, 8'b0};

	// ------------------------------------------------------------------
	// Stage 4: the four index-times-cosine products.
	// ------------------------------------------------------------------
	logic        v_s4, tir_s4;
	logic [39:0] x1_s4, y1_s4, x2_s4, y2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		tir_s4 <= tir_sq;
		x1_s4  <= et_sq * ci23;
		y1_s4  <= ei_sq * ct23;
		x2_s4  <= ei_sq * ci23;
		y2_s4  <= et_sq * ct23;
	end

	// ------------------------------------------------------------------
	// Stage 5: difference and sum for each amplitude ratio.
	// ------------------------------------------------------------------
	logic        v_s5, tir_s5, z1_s5, z2_s5;
	logic [39:0] d1_s5, s1_s5, d2_s5, s2_s5;
	logic [39:0] sum1, sum2;

	assign sum1 = x1_s4 + y1_s4;
	assign sum2 = x2_s4 + y2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tir_s5 <= tir_s4;
		d1_s5  <= (x1_s4 > y1_s4) ? (x1_s4 - y1_s4) : (y1_s4 - x1_s4);
		d2_s5  <= (x2_s4 > y2_s4) ? (x2_s4 - y2_s4) : (y2_s4 - x2_s4);
		s1_s5  <= sum1;
		s2_s5  <= sum2;
		z1_s5  <= sum1 == '0;
		z2_s5  <= sum2 == '0;
	end

	// ------------------------------------------------------------------
	// Amplitude ratios |p - q| / (p + q) in Q1.24, side by side.
	// ------------------------------------------------------------------
	logic        v_ra, v_rb;
	logic [24:0] rpar_q, rperp_q;
	logic [1:0]  tag_ra;
	logic        tag_rb;

	fdr_div_pipe #(
		.DW(40),
		.QB(25),
		.TW(2)
	) u_div_parl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.num       (d1_s5),
		.den       (s1_s5),
		.tag       ({tir_s5, z1_s5}),
		.out_valid (v_ra),
		.quot      (rpar_q),
		.out_tag   (tag_ra)
	);

	fdr_div_pipe #(
		.DW(40),
		.QB(25),
		.TW(1)
	) u_div_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.num       (d2_s5),
		.den       (s2_s5),
		.tag       (z2_s5),
		.out_valid (v_rb),
		.quot      (rperp_q),
		.out_tag   (tag_rb)
	);

	// A zero denominator means a ratio of 1.0.
	logic [24:0] rpar, rperp;
	assign rpar  = tag_ra[0] ? ONE_Q24 : rpar_q;
	assign rperp = tag_rb    ? ONE_Q24 : rperp_q;

	// ------------------------------------------------------------------
	// Stage 6: square each ratio.
	// ------------------------------------------------------------------
	logic        v_s6, tir_s6;
	logic [49:0] sqa_s6, sqb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_ra && v_rb;
		end
	end

	always_ff @(posedge clk) begin
		tir_s6 <= tag_ra[1];
		sqa_s6 <= rpar * rpar;
		sqb_s6 <= rperp * rperp;
	end

	// ------------------------------------------------------------------
	// Stage 7: mean, round half up to Q1.16, saturate, drive the result.
	// ------------------------------------------------------------------
	logic [50:0] sum_sq;
	logic [17:0] refl_rnd;
	assign sum_sq   = {1'b0, sqa_s6} + {1'b0, sqb_s6} + 51'(64'd1 << 32);
	assign refl_rnd = sum_sq[50:33];

	logic              v_s7, tir_s7;
	logic [REFL_W-1:0] refl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		tir_s7 <= tir_s6;
		if (tir_s6 || (refl_rnd > {1'b0, ONE_Q16})) begin
			refl_s7 <= ONE_Q16;
		end else begin
			refl_s7 <= refl_rnd[REFL_W-1:0];
		end
	end

	assign done           = v_s7;
	assign reflectance    = refl_s7;
	assign total_internal = tir_s7;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 96))
		else $error("done without a start 96 cycles earlier");

	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && total_internal) |-> (reflectance == ONE_Q16))
		else $error("total internal reflection with reflectance below 1.0");

	a_refl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reflectance <= ONE_Q16))
		else $error("reflectance above 1.0");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		v_ra == v_rb)
		else $error("amplitude ratio dividers out of step");

endmodule : fresnel_dielectric_reflectance_unit
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Fresnel dielectric reflectance unit: a table of
// directed transactions, then random ones, checked in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
	import fdr_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [COS_W-1:0] cos_incident;
	logic [ETA_W-1:0] eta_incident;
	logic [ETA_W-1:0] eta_transmitted;
	logic done;
	logic [REFL_W-1:0] reflectance;
	logic total_internal;

	typedef struct packed {
		logic [REFL_W-1:0] refl;
		logic              tir;
	} refl_result_t;

	// Directed row: inputs, plus a typed-in answer where one is obvious.
	typedef struct {
		logic [COS_W-1:0] cosv;
		logic [ETA_W-1:0] ei;
		logic [ETA_W-1:0] et;
		bit               has_answer;
		refl_result_t     answer;
	} directed_row_t;

	refl_result_t expected_q[$];
	int           mismatch_count;
	int           idle_pct;
	bit           finished;

	fresnel_dielectric_reflectance_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cos_incident(cos_incident), .eta_incident(eta_incident),
		.eta_transmitted(eta_transmitted), .done(done),
		.reflectance(reflectance), .total_internal(total_internal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Square root of a 64-bit value, truncated, bit by bit.
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// num / den as Q1.31, truncated, one quotient bit at a time (num <= den).
	function automatic logic [63:0] frac_q31(input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q = 0;
		rem = num;
		if (rem >= den) begin
			q = 1;
			rem = rem - den;
		end
		for (int i = 0; i < 31; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				q = q | 64'd1;
				rem = rem - den;
			end
		end
		return q;
	endfunction

	// Difference over sum as Q1.24; an empty sum counts as a ratio of one.
	function automatic logic [63:0] ratio_q24(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] d;
		logic [63:0] s;
		d = (x > y) ? x - y : y - x;
		s = x + y;
		if (s == 0) return 64'(ONE_Q24);
		return (d << 24) / s;
	endfunction

	function automatic refl_result_t fresnel_reflectance(input logic [COS_W-1:0] raw,
		input logic [ETA_W-1:0] ei_in, input logic [ETA_W-1:0] et_in);
		logic [63:0] ei, et, c, sin2, lhs, den, cos2t, ct23, ci23, rpar, rperp, total;
		refl_result_t r;
		ei = ei_in;
		et = et_in;
		if (raw != 0 && raw < 16'h8000) begin
			c = raw;
		end else begin
			// Leaving the surface: swap sides and fold the cosine positive.
			ei = et_in;
			et = ei_in;
			c = (64'h10000 - raw) & 64'hFFFF;
			if (raw == 16'h8000) c = 64'h8000;
		end
		sin2 = (64'd1 << 30) - c * c;
		lhs = ei * ei * sin2;
		den = (et * et) << 30;
		if (lhs >= den) begin
			r.refl = ONE_Q16;
			r.tir = 1'b1;
			return r;
		end
		// Quotient fits in Q1.31 since the numerator never exceeds den.
		cos2t = frac_q31(den - lhs, den);
		ct23 = root_floor(cos2t << 31) >> 8;
		ci23 = c << 8;
		rpar = ratio_q24(et * ci23, ei * ct23);
		rperp = ratio_q24(ei * ci23, et * ct23);
		total = (rpar * rpar + rperp * rperp + (64'd1 << 32)) >> 33;
		if (total > 64'(ONE_Q16)) total = 64'(ONE_Q16);
		r.refl = total[REFL_W-1:0];
		r.tir = 1'b0;
		return r;
	endfunction

	// Drive one transaction and hold it until the unit takes it.
	task automatic send_transaction(input logic [COS_W-1:0] cv, input logic [ETA_W-1:0] ei,
		input logic [ETA_W-1:0] et, input bit has_answer, input refl_result_t answer);
		refl_result_t model;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cos_incident <= cv;
		eta_incident <= ei;
		eta_transmitted <= et;
		@(posedge clk);
		while (busy) @(posedge clk);
		model = fresnel_reflectance(cv, ei, et);
		if (has_answer && model != answer)
			$display("directed row disagrees with predictor: cos=%h ei=%h et=%h", cv, ei, et);
		expected_q.push_back(has_answer ? answer : model);
		@(negedge clk);
	endtask

	// Drop start and wait for every outstanding result.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// Compare every strobed result with the oldest expectation.
	always @(posedge clk) begin
		refl_result_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: refl=%h tir=%b", reflectance, total_internal);
			end else begin
				exp_r = expected_q.pop_front();
				if (reflectance !== exp_r.refl || total_internal !== exp_r.tir) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: refl exp %h got %h, tir exp %b got %b",
							exp_r.refl, reflectance, exp_r.tir, total_internal);
				end
			end
		end
	end

	directed_row_t directed_rows[] = '{
		// Zero cosine counts as leaving; equal indices sit on the total
		// reflection boundary at grazing.
		'{16'h0000, 16'h1000, 16'h1000, 1'b0, '0},
		// Normal incidence, matched indices: no reflection at all.
		'{16'h7FFF, 16'h1000, 16'h1000, 1'b0, '0},
		'{16'h8000, 16'h1000, 16'h1000, 1'b0, '0},
		// Zero transmitted index always reflects totally.
		'{16'h7FFF, 16'h1000, 16'h0000, 1'b1, '{ONE_Q16, 1'b1}},
		'{16'h4000, 16'hFFFF, 16'h0000, 1'b1, '{ONE_Q16, 1'b1}},
		// Leaving with a zero index on the far side, after the swap.
		'{16'hC000, 16'h0000, 16'h1000, 1'b1, '{ONE_Q16, 1'b1}},
		// Grazing exit from a dense medium: total internal reflection.
		'{16'h0001, 16'h1800, 16'h1000, 1'b1, '{ONE_Q16, 1'b1}},
		'{16'hFFFF, 16'h1000, 16'h1800, 1'b1, '{ONE_Q16, 1'b1}},
		// Both indices zero: empty ratio denominators are not reached,
		// the test holds, so this is total reflection too.
		'{16'h7FFF, 16'h0000, 16'h0000, 1'b1, '{ONE_Q16, 1'b1}},
		// Zero incident index with positive cosine.
		'{16'h7FFF, 16'h0000, 16'hFFFF, 1'b0, '0},
		'{16'h0001, 16'h0000, 16'h0001, 1'b0, '0},
		// Extremes of the indices.
		'{16'h7FFF, 16'hFFFF, 16'h0001, 1'b0, '0},
		'{16'h7FFF, 16'h0001, 16'hFFFF, 1'b0, '0},
		'{16'h8000, 16'hFFFF, 16'h0001, 1'b0, '0},
		'{16'h8001, 16'hFFFF, 16'hFFFF, 1'b0, '0},
		// Air to glass and back at assorted angles.
		'{16'h5A82, 16'h1000, 16'h1800, 1'b0, '0},
		'{16'hA57E, 16'h1000, 16'h1800, 1'b0, '0},
		'{16'h2000, 16'h1000, 16'h1555, 1'b0, '0},
		'{16'h7000, 16'h1800, 16'h1000, 1'b0, '0},
		'{16'h0100, 16'h1000, 16'h1400, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0},
		'{16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0}
	};

	function automatic logic [ETA_W-1:0] pick_index();
		case ($urandom_range(3))
			0: return ETA_W'($urandom);
			1: return ETA_W'($urandom_range(16'h1000, 16'h3000));
			2: return ETA_W'($urandom_range(0, 15));
			default: return ETA_W'($urandom_range(16'hFFF0, 16'hFFFF));
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		start = 1'b0;
		cos_incident = '0;
		eta_incident = '0;
		eta_transmitted = '0;
		mismatch_count = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_transaction(directed_rows[i].cosv, directed_rows[i].ei, directed_rows[i].et,
				directed_rows[i].has_answer, directed_rows[i].answer);

		// Hold off until the pipeline is empty before the random phases.
		drain_pipeline();
		@(negedge clk);

		// Phases: no idling, sender mostly idle, sender sometimes idle, and no idling again.
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 67 : (phase == 2) ? 27 : 0;
			for (n = 0; n < 360; n++)
				send_transaction(COS_W'($urandom), pick_index(), pick_index(), 1'b0, '0);
		end

		drain_pipeline();
		repeat (110) @(negedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule : testbench
